@@ sv/utf8_text_sanitizer_core_defines.svh @@
// Assertion macros used by the sanitizer datapath.
`ifndef UTF8_TEXT_SANITIZER_CORE_DEFINES_SVH
`define UTF8_TEXT_SANITIZER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UTS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/uts_pkg.sv @@
// Shared types, constants and helper function of the UTF-8 text sanitizer.
`default_nettype none
package uts_pkg;

    localparam int unsigned WinDepth = 4;

    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLowerX    = 8'h78;

    typedef struct packed {
        logic load;
        logic latch;
        logic emit;
        logic consume;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic hold;
        logic out_free;
        logic grp_end;
    } dp_sts_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = 8'h30 + {4'h0, nib};
        end else begin
            res = 8'h37 + {4'h0, nib};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/uts_ctrl.sv @@
// Controller state machine that sequences load, decode and character emission.
`default_nettype none
module uts_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  uts_pkg::dp_sts_t     sts,
    output uts_pkg::dp_cmd_t     cmd
);
    import uts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.empty || sts.hold) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.latch  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.grp_end) begin
                        cmd.consume = 1'b1;
                        state_next  = S_DECIDE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/uts_dpath.sv @@
// Datapath: lookahead window, sequence decoder, escape generator and output register.
`default_nettype none
`include "utf8_text_sanitizer_core_defines.svh"
module uts_dpath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [7:0]      s_in_byte,
    input  wire logic            s_in_last,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_char,
    output logic                 m_out_last,
    input  uts_pkg::dp_cmd_t     cmd,
    output uts_pkg::dp_sts_t     sts
);
    import uts_pkg::*;

    localparam logic [1:0] K_PASS  = 2'd0;
    localparam logic [1:0] K_SPACE = 2'd1;
    localparam logic [1:0] K_ESC   = 2'd2;

    logic [7:0] w_reg [WinDepth];
    logic [7:0] w_next [WinDepth];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       last_reg;

    logic [1:0] kind_reg;
    logic [2:0] len_reg;
    logic [2:0] cons_reg;
    logic [1:0] idx_reg;

    logic       m_valid_reg;
    logic [7:0] m_char_reg;
    logic       m_last_reg;
    logic [7:0] char_next;
    logic       m_last_next;

    logic [1:0] kind_d;
    logic [2:0] len_d;
    logic [2:0] cons_d;
    logic       hold_d;

    always_comb begin
        logic [7:0] c;
        logic [2:0] need;
        logic       second;
        logic       ok;
        c      = w_reg[0];
        need   = 3'd0;
        second = 1'b0;
        ok     = 1'b0;
        kind_d = K_PASS;
        len_d  = 3'd1;
        cons_d = 3'd1;
        hold_d = 1'b0;
        if (c inside {[8'hC2:8'hDF]}) begin
            need = 3'd2;
        end else if (c inside {[8'hE0:8'hEF]}) begin
            need = 3'd3;
        end else if (c inside {[8'hF0:8'hF4]}) begin
            need = 3'd4;
        end
        case (c)
            8'hE0:   second = w_reg[1] inside {[8'hA0:8'hBF]};
            8'hED:   second = w_reg[1] inside {[8'h80:8'h9F]};
            8'hF0:   second = w_reg[1] inside {[8'h90:8'hBF]};
            8'hF4:   second = w_reg[1] inside {[8'h80:8'h8F]};
            default: second = (w_reg[1][7:6] == 2'b10);
        endcase
        ok = second
            && ((need < 3'd3) || (w_reg[2][7:6] == 2'b10))
            && ((need < 3'd4) || (w_reg[3][7:6] == 2'b10));
        if (c == 8'h00 || c == 8'h0D || c == 8'h0A) begin
            kind_d = K_SPACE;
        end else if (c == 8'h09) begin
            kind_d = K_PASS;
        end else if (c < 8'h20 || c == 8'h7F) begin
            kind_d = K_ESC;
            len_d  = 3'd4;
        end else if (c < 8'h80) begin
            kind_d = K_PASS;
        end else if (need != 3'd0 && cnt_reg < need) begin
            hold_d = !last_reg;
            kind_d = K_ESC;
            len_d  = 3'd4;
        end else if (need != 3'd0 && ok) begin
            kind_d = K_PASS;
            len_d  = need;
            cons_d = need;
        end else begin
            kind_d = K_ESC;
            len_d  = 3'd4;
        end
    end

    always_comb begin
        case (kind_reg)
            K_SPACE: char_next = ChSpace;
            K_ESC: begin
                case (idx_reg)
                    2'd0:    char_next = ChBackslash;
                    2'd1:    char_next = ChLowerX;
                    2'd2:    char_next = hex_char(w_reg[0][7:4]);
                    default: char_next = hex_char(w_reg[0][3:0]);
                endcase
            end
            default: char_next = w_reg[idx_reg];
        endcase
    end

    assign sts.empty    = (cnt_reg == 3'd0);
    assign sts.hold     = hold_d;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.grp_end  = ({1'b0, idx_reg} == (len_reg - 3'd1));

    assign m_last_next = last_reg && sts.grp_end && (cnt_reg == cons_reg);

    always_comb begin
        logic [2:0] src;
        src = 3'd0;
        for (int i = 0; i < WinDepth; i++) begin
            w_next[i] = w_reg[i];
        end
        cnt_next = cnt_reg;
        if (cmd.load) begin
            w_next[cnt_reg[1:0]] = s_in_byte;
            cnt_next             = cnt_reg + 3'd1;
        end else if (cmd.consume) begin
            for (int i = 0; i < WinDepth; i++) begin
                src = 3'(i) + cons_reg;
                if (src < 3'(WinDepth)) begin
                    w_next[i] = w_reg[src[1:0]];
                end
            end
            cnt_next = cnt_reg - cons_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 3'd0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.latch) begin
                idx_reg <= 2'd0;
            end else if (cmd.emit) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WinDepth; i++) begin
            w_reg[i] <= w_next[i];
        end
        if (cmd.load) begin
            last_reg <= s_in_last;
        end
        if (cmd.latch) begin
            kind_reg <= kind_d;
            len_reg  <= len_d;
            cons_reg <= cons_d;
        end
        if (cmd.emit) begin
            m_char_reg <= char_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_out_last = m_last_reg;

    `UTS_ASSERT_SAME(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 3'd4, "window count out of range")
    `UTS_ASSERT_SAME(a_load_room, aclk, aresetn, cmd.load, cnt_reg <= 3'd3, "item loaded into a full window")
    `UTS_ASSERT_SAME(a_consume_ok, aclk, aresetn, cmd.consume, cons_reg <= cnt_reg, "consumed more bytes than held")
    `UTS_ASSERT_NEXT(a_last_empty, aclk, aresetn, cmd.emit && m_last_next, cnt_reg == 3'd0, "final character left bytes pending")

endmodule
`default_nettype wire

@@ sv/utf8_text_sanitizer_core.sv @@
// UTF-8 text sanitizer top level.
// The s_ channel takes one raw byte per item (s_in_byte) with s_in_last set on the final
// byte of a string. The m_ channel returns sanitized characters one per item, with
// m_out_last set on the final character that the final byte produces.
// Both channels use valid/ready; an item moves when valid and ready are both high.
// A byte passes a load step, a decode step for each group it resolves plus a closing
// decode that finds no resolvable group, and an emit step for each character, which
// waits while the receiver stalls; a valid multi-byte sequence resolves in one decode
// and emits one character per byte.
// After its byte is accepted, the first character passes the decode and emit states before m_valid rises.
// The single output port bounds throughput at one character per cycle; the controller
// handles one byte at a time and accepts the next byte only once the window holds no
// resolvable group.
// Lead bytes of incomplete sequences stay in a four-entry window until more bytes
// arrive or the string ends.
// Synchronous active-low reset empties the window and drops any held output item, and
// no item is accepted while reset is held.
// When the receiver stalls, the output register holds its item and emission pauses;
// no input is accepted until the pending groups have drained.
`default_nettype none
module utf8_text_sanitizer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_out_last
);
    import uts_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    uts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    uts_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
`default_nettype wire

@@ verif/text_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks the sanitized character stream.
package text_scoreboard_pkg;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    class text_scoreboard;
        logic [7:0]  held_bytes[3];
        int unsigned held_count;
        logic [7:0]  expected_chars[$];
        logic        expected_lasts[$];
        int unsigned errors;
        string       hex_digits;

        function new();
            held_count = 0;
            errors     = 0;
            hex_digits = "0123456789ABCDEF";
        endfunction

        function bit drained();
            return expected_chars.size() == 0;
        endfunction

        function void push_char(logic [7:0] ch);
            expected_chars = {expected_chars, ch};
            expected_lasts = {expected_lasts, 1'b0};
        endfunction

        function void push_escape(logic [7:0] ch);
            push_char(CH_BACKSLASH);
            push_char(CH_X);
            push_char(8'(hex_digits[ch[7:4]]));
            push_char(8'(hex_digits[ch[3:0]]));
        endfunction

        // Runs one byte through the held window and queues every character it resolves.
        function void note_byte(logic [7:0] in_byte, logic in_last);
            logic [7:0]  win[4];
            logic [7:0]  c;
            logic [7:0]  b1;
            logic        ok;
            int unsigned n;
            int unsigned pos;
            int unsigned need;
            int unsigned i;
            int unsigned first;
            first = expected_chars.size();
            for (i = 0; i < held_count; i++) win[i] = held_bytes[i];
            win[held_count] = in_byte;
            n = held_count + 1;
            pos = 0;
            while (pos < n) begin
                c = win[pos];
                if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
                    push_char(CH_SPACE);
                    pos++;
                end else if (c == CH_TAB) begin
                    push_char(c);
                    pos++;
                end else if (c < CH_SPACE || c == CH_DEL) begin
                    push_escape(c);
                    pos++;
                end else if (c < 8'h80) begin
                    push_char(c);
                    pos++;
                end else begin
                    if (c >= 8'hC2 && c <= 8'hDF) need = 2;
                    else if (c >= 8'hE0 && c <= 8'hEF) need = 3;
                    else if (c >= 8'hF0 && c <= 8'hF4) need = 4;
                    else need = 0;
                    if (need != 0 && n - pos < need && !in_last) break;
                    ok = 1'b0;
                    if (need != 0 && n - pos >= need) begin
                        b1 = win[pos + 1];
                        case (c)
                            8'hE0: ok = (b1 >= 8'hA0 && b1 <= 8'hBF);
                            8'hED: ok = (b1 >= 8'h80 && b1 <= 8'h9F);
                            8'hF0: ok = (b1 >= 8'h90 && b1 <= 8'hBF);
                            8'hF4: ok = (b1 >= 8'h80 && b1 <= 8'h8F);
                            default: ok = (b1[7:6] == 2'b10);
                        endcase
                        if (need >= 3 && win[pos + 2][7:6] != 2'b10) ok = 1'b0;
                        if (need >= 4 && win[pos + 3][7:6] != 2'b10) ok = 1'b0;
                    end
                    if (ok) begin
                        for (i = 0; i < need; i++) push_char(win[pos + i]);
                        pos += need;
                    end else begin
                        push_escape(c);
                        pos++;
                    end
                end
            end
            held_count = 0;
            while (pos < n && held_count < 3) begin
                held_bytes[held_count] = win[pos];
                held_count++;
                pos++;
            end
            if (in_last && expected_chars.size() > first)
                expected_lasts[expected_lasts.size() - 1] = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_char(logic [7:0] out_char, logic out_last);
            logic [7:0] want_char;
            logic       want_last;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b", out_char, out_last));
            end else begin
                want_char = expected_chars.pop_front();
                want_last = expected_lasts.pop_front();
                if (out_char !== want_char)
                    report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", out_char, want_char));
                if (out_last !== want_last)
                    report_mismatch($sformatf("last %0b, wanted %0b on char 0x%02h",
                                              out_last, want_last, want_char));
            end
        endtask
    endclass

endpackage

@@ verif/testbench.sv @@
// Top-level testbench that drives byte strings into the sanitizer and checks its output.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import text_scoreboard_pkg::*;

    localparam int unsigned TOTAL_BYTES  = 180;
    localparam int unsigned IDLE_PCT     = 14;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_char;
    logic       m_out_last;

    logic        quiet = 1'b0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned string_count = 0;
    logic [7:0]  text_q[$];

    text_scoreboard board = new();

    always #6 aclk = ~aclk;

    utf8_text_sanitizer_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_char(m_out_char, m_out_last);
        m_ready <= aresetn && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_text();
        int unsigned i;
        logic        is_last;
        for (i = 0; i < text_q.size(); i++) begin
            is_last = (i == text_q.size() - 1);
            while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_in_byte <= text_q[i];
            s_in_last <= is_last;
            do @(posedge aclk); while (!s_ready);
            board.note_byte(text_q[i], is_last);
            bytes_sent++;
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (!board.drained());
    endtask

    function automatic void add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic void add_token();
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        logic [7:0]  lead;
        logic [7:0]  second;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            add_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 35) begin
            case ($urandom_range(0, 5))
                0: add_byte(CH_NUL);
                1: add_byte(CH_TAB);
                2: add_byte(CH_LF);
                3: add_byte(CH_CR);
                4: add_byte(CH_DEL);
                default: add_byte(8'($urandom_range(0, 31)));
            endcase
        end else if (pick < 80) begin
            len = $urandom_range(2, 4);
            case (len)
                2: begin
                    lead   = 8'($urandom_range(8'hC2, 8'hDF));
                    second = cont_byte();
                end
                3: begin
                    lead = 8'($urandom_range(8'hE0, 8'hEF));
                    if (lead == 8'hE0) second = 8'($urandom_range(8'hA0, 8'hBF));
                    else if (lead == 8'hED) second = 8'($urandom_range(8'h80, 8'h9F));
                    else second = cont_byte();
                end
                default: begin
                    lead = 8'($urandom_range(8'hF0, 8'hF4));
                    if (lead == 8'hF0) second = 8'($urandom_range(8'h90, 8'hBF));
                    else if (lead == 8'hF4) second = 8'($urandom_range(8'h80, 8'h8F));
                    else second = cont_byte();
                end
            endcase
            add_byte(lead);
            add_byte(second);
            for (i = 2; i < len; i++) add_byte(cont_byte());
            if (pick >= 68) begin
                cut = $urandom_range(1, len - 1);
                if (pick[0]) text_q[text_q.size() - len + cut] = 8'($urandom_range(0, 255));
                else repeat (cut) text_q.delete(text_q.size() - 1);
            end
        end else begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        text_q = '{8'h00, 8'h0D, 8'h0A, 8'h09, 8'h1F, 8'h7F, 8'h7E, 8'h80, 8'hFF};
        send_text();
        text_q = '{8'hC2, 8'h80, 8'hE0, 8'h9F, 8'hF0, 8'h90, 8'h80, 8'h80,
                   8'hED, 8'hA0, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        text_q = '{8'hF1, 8'h80};
        send_text();
        drain_results();

        while (bytes_sent < TOTAL_BYTES) begin
            text_q.delete();
            repeat ($urandom_range(1, 5)) add_token();
            if (string_count == 8) drain_results();
            quiet <= (string_count >= 14 && string_count < 26);
            send_text();
            string_count++;
        end
        quiet <= 1'b0;

        drain_results();
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.drained()) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/uts_pkg.sv
sv/uts_ctrl.sv
sv/uts_dpath.sv
sv/utf8_text_sanitizer_core.sv
verif/text_scoreboard_pkg.sv
verif/testbench.sv
